// ===== rtl/htsp_pkg.sv =====
// ----------------------------------------------------------------------------
// htsp_pkg
// Shared constants and types of the stride-probe hash table: table geometry,
// command, tag and status codes, controller states and control bundles.
// ----------------------------------------------------------------------------
package htsp_pkg;

    localparam int TABLE_SIZE = 64;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 31;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = SLOT_W + 1;
    localparam int STRIDE_W   = 6;
    localparam int LIMIT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int TAG_W      = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // Slot tags.
    localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
    localparam logic [TAG_W-1:0] TAG_LIVE  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_GONE  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd1;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 6'd61;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd48;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } slot_word_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic rd_en;
        logic step;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic resolved;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/htsp_if.sv =====
// ----------------------------------------------------------------------------
// htsp request and response channels
// Valid/ready channels carrying one table request and one response.
// ----------------------------------------------------------------------------
interface htsp_req_if
    import htsp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;

    modport source (output valid, output command, output key, input ready);
    modport sink (input valid, input command, input key, output ready);
endinterface

interface htsp_rsp_if
    import htsp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  occupancy;

    modport source (output valid, output status, output slot, output occupancy, input ready);
    modport sink (input valid, input status, input slot, input occupancy, output ready);
endinterface

// ===== rtl/htsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// htsp_ctrl
// Probe sequencer: accepts a request, alternates slot read and check until
// the datapath resolves the request, then commits it to the response register.
// ----------------------------------------------------------------------------
module htsp_ctrl
    import htsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!status.resolved)
                begin
                    state_next = S_READ;
                end
                else if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            S_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            S_CHECK:
            begin
                cmd.step   = !status.resolved;
                // A finished request waits here while the response register is held.
                cmd.commit = status.resolved && status.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/htsp_datapath.sv =====
// ----------------------------------------------------------------------------
// htsp_datapath
// Slot memory with per-entry valid bits, probe index and pass counter,
// configuration registers, live count and the response register.
// ----------------------------------------------------------------------------
module htsp_datapath
    import htsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CMD_W-1:0]      req_command,
    input  logic [KEY_W-1:0]      req_key,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    htsp_rsp_if.source            rsp
);

    slot_word_t mem [TABLE_SIZE];
    slot_word_t rd_q;

    logic [TABLE_SIZE-1:0] valid_reg;
    logic                  rd_valid_reg;
    logic [CMD_W-1:0]      cmd_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic [SLOT_W-1:0]     n_reg;
    logic [COUNT_W-1:0]    live_reg;
    logic [COUNT_W-1:0]    live_next;
    logic [STRIDE_W-1:0]   stride_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [COUNT_W-1:0]    out_occ_reg;

    logic [TAG_W-1:0]      tag;
    logic                  last;
    logic                  match;
    logic                  resolved;
    logic [STATUS_W-1:0]   res_status;
    logic                  wr_en;
    logic [TAG_W-1:0]      wr_tag;
    logic                  inc;
    logic                  dec;

    // Slot memory: one access per cycle, registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
        begin
            mem[idx_reg] <= '{tag: wr_tag, key: key_reg};
        end
        if (cmd.rd_en)
        begin
            rd_q <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            live_reg     <= '0;
            stride_reg   <= STRIDE_RESET;
            limit_reg    <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STRIDE: stride_reg <= cfg_data[STRIDE_W-1:0];
                    CFG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                    default:    limit_reg  <= limit_reg;
                endcase
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[idx_reg];
            end
            if (cmd.commit)
            begin
                live_reg <= live_next;
                if (wr_en)
                begin
                    valid_reg[idx_reg] <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= req_command;
            key_reg <= req_key;
            idx_reg <= req_key[SLOT_W-1:0];
            n_reg   <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + SLOT_W'(stride_reg);
            n_reg   <= n_reg + 1'b1;
        end
        if (cmd.commit)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= (res_status == STATUS_OK) ? idx_reg : '0;
            out_occ_reg    <= live_next;
        end
    end

    // Never-written entries read as empty through their valid bit.
    assign tag   = rd_valid_reg ? rd_q.tag : TAG_EMPTY;
    assign last  = (n_reg == SLOT_W'(TABLE_SIZE - 1));
    assign match = (tag == TAG_LIVE) && (rd_q.key == key_reg);

    always_comb
    begin
        resolved   = 1'b0;
        res_status = STATUS_NOTFOUND;
        wr_en      = 1'b0;
        wr_tag     = TAG_LIVE;
        inc        = 1'b0;
        dec        = 1'b0;
        case (cmd_reg)
            CMD_SEARCH, CMD_DELETE:
            begin
                if (match)
                begin
                    resolved   = 1'b1;
                    res_status = STATUS_OK;
                    if (cmd_reg == CMD_DELETE)
                    begin
                        wr_en  = 1'b1;
                        wr_tag = TAG_GONE;
                        dec    = 1'b1;
                    end
                end
                else if (tag == TAG_EMPTY || last)
                begin
                    resolved = 1'b1;
                end
            end
            CMD_INSERT:
            begin
                if (live_reg >= COUNT_W'(limit_reg))
                begin
                    resolved   = 1'b1;
                    res_status = STATUS_FULL;
                end
                else if (tag != TAG_LIVE)
                begin
                    resolved   = 1'b1;
                    res_status = STATUS_OK;
                    wr_en      = 1'b1;
                    inc        = 1'b1;
                end
                else if (last)
                begin
                    resolved   = 1'b1;
                    res_status = STATUS_FULL;
                end
            end
            default:
            begin
                resolved = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        live_next = live_reg;
        if (inc)
        begin
            live_next = live_reg + 1'b1;
        end
        else if (dec && live_reg != '0)
        begin
            live_next = live_reg - 1'b1;
        end
    end

    assign status.resolved = resolved;
    assign status.out_free = !out_valid_reg || rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.slot      = out_slot_reg;
    assign rsp.occupancy = out_occ_reg;

endmodule

// ===== rtl/hash_table_stride_probe_core.sv =====
// ----------------------------------------------------------------------------
// hash_table_stride_probe_core
// Open-addressing key table with constant-stride probing: search, insert
// and delete of 31-bit keys, tombstones on delete, one response per request.
// ----------------------------------------------------------------------------
//  channel | direction | payload                     | handshake
//  req     | in        | command, key                | valid / ready
//  rsp     | out       | status, slot, occupancy     | valid / ready
//  cfg     | in        | cfg_index, cfg_data         | cfg_we, no wait
//
//  A request walks p probes (1 to 64): the slot memory is read once per
//  probe and its registered data checked in the following cycle. The
//  response register is loaded at the last check.
//  Reset clears all slot valid bits at once, so no clearing pass is needed.
//  A response held by rsp.ready stalls the finished request in its check
//  state; a new request is taken as soon as the previous one commits.
// ----------------------------------------------------------------------------
module hash_table_stride_probe_core
    import htsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    htsp_req_if.sink              req,
    htsp_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic       req_ready;

    assign req.ready = req_ready;

    htsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    htsp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_command (req.command),
        .req_key     (req.key),
        .cmd         (dp_cmd),
        .status      (dp_status),
        .rsp         (rsp)
    );

    // Only one request is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in flight");

    // A commit always lands in the response register.
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |=> rsp.valid)
        else $error("committed response not presented");

    // Misses and refusals report slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STATUS_OK) |-> (rsp.slot == '0))
        else $error("nonzero slot on a failed request");

    // Live count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.occupancy <= COUNT_W'(TABLE_SIZE)))
        else $error("occupancy beyond table size");

endmodule
